// File: rtl/core/rgba8_porter_duff_blend_assert.svh
// Assertion macros used by the blend unit rgba8_porter_duff_blend.
`ifndef RGBA8_PORTER_DUFF_BLEND_ASSERT_SVH
`define RGBA8_PORTER_DUFF_BLEND_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RPDB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rpdb_pkg.sv
package rpdb_pkg;

    typedef enum logic [4:0] {
        MODE_SRCATOP    = 5'd0,
        MODE_DSTATOP    = 5'd1,
        MODE_SRCIN      = 5'd2,
        MODE_DSTIN      = 5'd3,
        MODE_SRCOUT     = 5'd4,
        MODE_DSTOUT     = 5'd5,
        MODE_SRCOVER    = 5'd6,
        MODE_DSTOVER    = 5'd7,
        MODE_MODULATE   = 5'd8,
        MODE_MULTIPLY   = 5'd9,
        MODE_PLUS       = 5'd10,
        MODE_SCREEN     = 5'd11,
        MODE_XOR        = 5'd12,
        MODE_DARKEN     = 5'd13,
        MODE_LIGHTEN    = 5'd14,
        MODE_DIFFERENCE = 5'd15,
        MODE_EXCLUSION  = 5'd16,
        MODE_HARDLIGHT  = 5'd17,
        MODE_OVERLAY    = 5'd18
    } t_mode;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
    } t_in_pix;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
    } t_out_pix;

    // Approximate divide by 255: ((v + 255) mod 2^16) >> 8.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [15:0] w;
        w = v + 16'd255;
        return w[15:8];
    endfunction

endpackage

// File: rtl/core/rpdb_chan.sv
module rpdb_chan (
    input  rpdb_pkg::t_mode i_mode,
    input  logic [7:0]      i_s,
    input  logic [7:0]      i_d,
    input  logic [7:0]      i_sa,
    input  logic [7:0]      i_da,
    output logic [15:0]     o_val
);
    import rpdb_pkg::*;

    logic [15:0] s16, d16, sa16, da16, isa16, ida16;
    logic [15:0] p, q, sid, dis, sd, sum_sd;
    logic [15:0] pq_min, pq_max, prod_diff, t_hi, t_term, hard_sum;
    logic [8:0]  plus_sum;
    logic        low;

    always_comb begin
        s16   = {8'd0, i_s};
        d16   = {8'd0, i_d};
        sa16  = {8'd0, i_sa};
        da16  = {8'd0, i_da};
        isa16 = {8'd0, 8'd255 - i_sa};
        ida16 = {8'd0, 8'd255 - i_da};

        p      = s16 * da16;
        q      = d16 * sa16;
        sid    = s16 * ida16;
        dis    = d16 * isa16;
        sd     = s16 * d16;
        sum_sd = s16 + d16;
        pq_min = (p < q) ? p : q;
        pq_max = (p < q) ? q : p;

        plus_sum = {1'b0, i_s} + {1'b0, i_d};

        if (i_mode == MODE_HARDLIGHT) begin
            low = ({i_s, 1'b0} <= {1'b0, i_sa});
        end else begin
            low = ({i_d, 1'b0} <= {1'b0, i_da});
        end
        prod_diff = (sa16 - s16) * (da16 - d16);
        t_hi      = sa16 * da16 - {prod_diff[14:0], 1'b0};
        t_term    = low ? {sd[14:0], 1'b0} : t_hi;
        hard_sum  = sid + dis + t_term;

        unique case (i_mode)
            MODE_SRCATOP:    o_val = {8'd0, div255(p + dis)};
            MODE_DSTATOP:    o_val = {8'd0, div255(q + sid)};
            MODE_SRCIN:      o_val = {8'd0, div255(p)};
            MODE_DSTIN:      o_val = {8'd0, div255(q)};
            MODE_SRCOUT:     o_val = {8'd0, div255(sid)};
            MODE_DSTOUT:     o_val = {8'd0, div255(dis)};
            MODE_DSTOVER:    o_val = d16 + {8'd0, div255(sid)};
            MODE_MODULATE:   o_val = {8'd0, div255(sd)};
            MODE_MULTIPLY:   o_val = {8'd0, div255(sid + dis + sd)};
            MODE_PLUS:       o_val = plus_sum[8] ? 16'd255 : {8'd0, plus_sum[7:0]};
            MODE_SCREEN:     o_val = sum_sd - {8'd0, div255(sd)};
            MODE_XOR:        o_val = {8'd0, div255(sid + dis)};
            MODE_DARKEN:     o_val = sum_sd - {8'd0, div255(pq_max)};
            MODE_LIGHTEN:    o_val = sum_sd - {8'd0, div255(pq_min)};
            MODE_DIFFERENCE: o_val = sum_sd - {7'd0, div255(pq_min), 1'b0};
            MODE_EXCLUSION:  o_val = sum_sd - {7'd0, div255(sd), 1'b0};
            MODE_HARDLIGHT,
            MODE_OVERLAY:    o_val = {8'd0, div255(hard_sum)};
            default:         o_val = s16 + {8'd0, div255(dis)};
        endcase
    end

endmodule

// File: rtl/core/rgba8_porter_duff_blend.sv
// RGBA8 blend unit: blends a premultiplied source pixel over a destination
// pixel with one of 19 Porter-Duff or separable blend modes.
// Input channel: i_valid / o_ready with i_pix (source and destination RGBA).
// Output channel: o_valid / i_ready with o_pix (four 16-bit channels).
// Mode register: written by i_cfg_we / i_cfg_wdata, taken at once; codes
// above overlay are stored as srcover. Write only while the block is idle.
// Path: an accepted item is loaded into the input register, then into the
// result register, which drives o_valid.
// Throughput: one pixel per cycle while i_ready stays high, set by the single-pass channel datapath.
// Stall: while the receiver holds i_ready low, the result register holds
// its item and the input register still takes one more item; o_ready drops
// only when both registers are full and the receiver stalls.
// Reset (synchronous, i_rst_n low): both registers empty, mode srcover.
module rgba8_porter_duff_blend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  rpdb_pkg::t_in_pix  i_pix,
    output logic               o_valid,
    input  logic               i_ready,
    output rpdb_pkg::t_out_pix o_pix
);
    import rpdb_pkg::*;

    `include "rgba8_porter_duff_blend_assert.svh"

    t_mode    r_mode, n_mode, w_amode;
    logic     r_s1_valid, r_out_valid;
    t_in_pix  r_s1_pix;
    t_out_pix r_out_pix, n_out_pix;
    logic     w_out_free, w_in_take;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = !r_s1_valid || w_out_free;
    assign w_in_take  = i_valid && o_ready;
    assign o_valid    = r_out_valid;
    assign o_pix      = r_out_pix;

    assign n_mode  = (i_cfg_wdata > MODE_OVERLAY) ? MODE_SRCOVER : t_mode'(i_cfg_wdata);
    assign w_amode = (r_mode >= MODE_DARKEN) ? MODE_SRCOVER : r_mode;

    rpdb_chan u_red (
        .i_mode (r_mode),
        .i_s    (r_s1_pix.src_red),
        .i_d    (r_s1_pix.dst_red),
        .i_sa   (r_s1_pix.src_alpha),
        .i_da   (r_s1_pix.dst_alpha),
        .o_val  (n_out_pix.out_red)
    );

    rpdb_chan u_green (
        .i_mode (r_mode),
        .i_s    (r_s1_pix.src_green),
        .i_d    (r_s1_pix.dst_green),
        .i_sa   (r_s1_pix.src_alpha),
        .i_da   (r_s1_pix.dst_alpha),
        .o_val  (n_out_pix.out_green)
    );

    rpdb_chan u_blue (
        .i_mode (r_mode),
        .i_s    (r_s1_pix.src_blue),
        .i_d    (r_s1_pix.dst_blue),
        .i_sa   (r_s1_pix.src_alpha),
        .i_da   (r_s1_pix.dst_alpha),
        .o_val  (n_out_pix.out_blue)
    );

    rpdb_chan u_alpha (
        .i_mode (w_amode),
        .i_s    (r_s1_pix.src_alpha),
        .i_d    (r_s1_pix.dst_alpha),
        .i_sa   (r_s1_pix.src_alpha),
        .i_da   (r_s1_pix.dst_alpha),
        .o_val  (n_out_pix.out_alpha)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SRCOVER;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= n_mode;
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Hold payload while stalled; advance on a free slot.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_pix <= i_pix;
        end
        if (w_out_free && r_s1_valid) begin
            r_out_pix <= n_out_pix;
        end
    end

    `RPDB_ASSERT_NEXT(a_take_fills_s1, w_in_take, r_s1_valid,
        "accepted item missing from input register")
    `RPDB_ASSERT_NEXT(a_s1_advances, r_s1_valid && w_out_free, r_out_valid,
        "item in input register did not reach result register")
    `RPDB_ASSERT_NOW(a_ready_low_full, !o_ready, r_s1_valid && r_out_valid && !i_ready,
        "input stalled while a register was free")

endmodule
